[rtl/core/two_level_page_walk_with_tlb_defines.svh]
// Assertion macros for the page walk block.
`ifndef TWO_LEVEL_PAGE_WALK_WITH_TLB_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALK_WITH_TLB_DEFINES_SVH
`ifndef SYNTHESIS
`define PW_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PW_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PW_ASSERT_IMP(label, clk, rst_n, a, c)
`define PW_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/core/tlpw_pkg.sv]
// Shared types and constants for the page walk block.
package tlpw_pkg;
    localparam int TlbEntriesDefault = 64;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_RESPONSE  = 2'd1,
        OP_FLUSH_ALL = 2'd2,
        OP_FLUSH_ONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_TRANSLATED = 3'd0,
        KIND_FAULT      = 3'd1,
        KIND_READ       = 3'd2,
        KIND_WRITE      = 3'd3,
        KIND_FLUSHED    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_DIR   = 2'd1,
        PHASE_TABLE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        BACK_IDLE = 2'd0,
        BACK_WORK = 2'd1,
        BACK_SECOND = 2'd2
    } back_state_t;

    localparam logic [0:0] CFG_PAGING = 1'b0;
    localparam logic [0:0] CFG_DIR_BASE = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] vaddr;
        logic [31:0] read_data;
        logic        read_ok;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] trans_addr;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic [31:0] fault_addr;
        logic        tlb_hit;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] fault_total;
        logic        last;
    } out_word_t;

    typedef struct packed {
        in_word_t    word;
        logic        paging;
    } queue_word_t;
endpackage

[rtl/core/tlpw_front.sv]
// Front end: takes commands and queues them with the paging mode.
module tlpw_front
    import tlpw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_word_t    in_word,
    input  logic        paging,
    input  logic        pop,
    output logic        busy,
    output logic        q_valid,
    output queue_word_t q_word
);
    localparam int PtrW = $clog2(QueueDepth);
    queue_word_t mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_reg, rd_reg;
    logic [PtrW:0] cnt_reg, cnt_next;
    logic push;

    assign busy = (cnt_reg == (PtrW+1)'(QueueDepth));
    assign push = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_word = mem_reg[rd_reg];
    assign cnt_next = cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= '{word: in_word, paging: paging};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end
endmodule

[rtl/core/tlpw_back.sv]
// Back end: TLB search, walk sequencing, counters and results.
`include "two_level_page_walk_with_tlb_defines.svh"
module tlpw_back
    import tlpw_pkg::*;
#(
    parameter int TLB_ENTRIES = TlbEntriesDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  queue_word_t q_word,
    output logic        pop,
    input  logic        dir_write,
    input  logic [19:0] dir_base,
    output logic        done,
    output out_word_t   result
);
    localparam int IdxW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [19:0] vpage_reg [TLB_ENTRIES];
    logic [19:0] ppage_reg [TLB_ENTRIES];
    logic [IdxW-1:0] rp_reg;
    phase_t phase_reg;
    logic [31:0] wva_reg, tea_reg, fa_reg, hc_reg, mc_reg, fc_reg;
    back_state_t st_reg, st_next;
    queue_word_t cur_reg;
    logic [TLB_ENTRIES-1:0] match_reg;
    logic [31:0] phys2_reg;
    out_word_t res_reg;
    logic done_reg;

    logic [IdxW-1:0] hit_idx;
    logic hit_any;
    in_word_t w;

    function automatic logic [IdxW-1:0] hitv_idx(input logic [TLB_ENTRIES-1:0] v);
        logic [IdxW-1:0] r;
        r = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i]) r = IdxW'(i);
        end
        return r;
    endfunction

    assign w = cur_reg.word;
    assign done = done_reg;
    assign result = res_reg;

    always_comb
    begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IdxW'(i);
                hit_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (st_reg)
            BACK_IDLE: st_next = q_valid ? BACK_WORK : BACK_IDLE;
            BACK_WORK: st_next = (w.operation == OP_RESPONSE && phase_reg == PHASE_TABLE
                                  && w.read_ok && w.read_data[0]) ? BACK_SECOND : BACK_IDLE;
            BACK_SECOND: st_next = BACK_IDLE;
            default: st_next = BACK_IDLE;
        endcase
    end

    assign pop = (st_reg == BACK_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_word;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                match_reg[i] <= vpage_reg[i] == q_word.word.vaddr[31:12];
            end
        end
        if (st_reg == BACK_WORK && w.operation == OP_RESPONSE && phase_reg == PHASE_TABLE
            && w.read_ok && w.read_data[0])
        begin
            vpage_reg[rp_reg] <= wva_reg[31:12];
            ppage_reg[rp_reg] <= w.read_data[31:12];
            phys2_reg <= {w.read_data[31:12], wva_reg[11:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BACK_IDLE;
            valid_reg <= '0;
            rp_reg <= '0;
            phase_reg <= PHASE_IDLE;
            wva_reg <= '0;
            tea_reg <= '0;
            fa_reg <= '0;
            hc_reg <= '0;
            mc_reg <= '0;
            fc_reg <= '0;
            done_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            logic [TLB_ENTRIES-1:0] hitv;
            logic [31:0] hc, mc, fc, fa;
            hitv = valid_reg & match_reg;
            hc = hc_reg; mc = mc_reg; fc = fc_reg; fa = fa_reg;
            st_reg <= st_next;
            done_reg <= 1'b0;
            res_reg <= '0;
            if (st_reg == BACK_WORK)
            begin
                unique case (op_t'(w.operation))
                    OP_TRANSLATE:
                    begin
                        if (phase_reg == PHASE_IDLE)
                        begin
                            done_reg <= 1'b1;
                            res_reg.last <= 1'b1;
                            if (!cur_reg.paging)
                            begin
                                res_reg.kind <= KIND_TRANSLATED;
                                res_reg.trans_addr <= w.vaddr;
                            end
                            else if (hitv != '0)
                            begin
                                hc = hc + 1;
                                res_reg.kind <= KIND_TRANSLATED;
                                res_reg.tlb_hit <= 1'b1;
                                res_reg.trans_addr <= {ppage_reg[hitv_idx(hitv)], w.vaddr[11:0]};
                            end
                            else
                            begin
                                mc = mc + 1;
                                wva_reg <= w.vaddr;
                                phase_reg <= PHASE_DIR;
                                res_reg.kind <= KIND_READ;
                                res_reg.mem_addr <= {dir_base, 12'd0}
                                                  + {20'd0, w.vaddr[31:22], 2'b00};
                            end
                        end
                    end
                    OP_RESPONSE:
                    begin
                        if (phase_reg != PHASE_IDLE)
                        begin
                            done_reg <= 1'b1;
                            if (!w.read_ok || !w.read_data[0])
                            begin
                                fa = wva_reg;
                                fc = fc + 1;
                                phase_reg <= PHASE_IDLE;
                                res_reg.kind <= KIND_FAULT;
                                res_reg.last <= 1'b1;
                            end
                            else if (phase_reg == PHASE_DIR)
                            begin
                                tea_reg <= {w.read_data[31:12], 12'd0}
                                         + {20'd0, wva_reg[21:12], 2'b00};
                                phase_reg <= PHASE_TABLE;
                                res_reg.kind <= KIND_READ;
                                res_reg.mem_addr <= {w.read_data[31:12], 12'd0}
                                                  + {20'd0, wva_reg[21:12], 2'b00};
                                res_reg.last <= 1'b1;
                            end
                            else
                            begin
                                valid_reg[rp_reg] <= 1'b1;
                                rp_reg <= (rp_reg == IdxW'(TLB_ENTRIES - 1)) ? '0 : rp_reg + 1'b1;
                                phase_reg <= PHASE_IDLE;
                                res_reg.kind <= KIND_WRITE;
                                res_reg.mem_addr <= tea_reg;
                                res_reg.mem_wdata <= w.read_data | 32'h20;
                            end
                        end
                    end
                    OP_FLUSH_ALL:
                    begin
                        valid_reg <= '0;
                        done_reg <= 1'b1;
                        res_reg.kind <= KIND_FLUSHED;
                        res_reg.last <= 1'b1;
                    end
                    OP_FLUSH_ONE:
                    begin
                        if (hitv != '0) valid_reg[hitv_idx(hitv)] <= 1'b0;
                        done_reg <= 1'b1;
                        res_reg.kind <= KIND_FLUSHED;
                        res_reg.last <= 1'b1;
                    end
                    default: ;
                endcase
            end
            else if (st_reg == BACK_SECOND)
            begin
                done_reg <= 1'b1;
                res_reg.kind <= KIND_TRANSLATED;
                res_reg.trans_addr <= phys2_reg;
                res_reg.last <= 1'b1;
            end
            if (dir_write) valid_reg <= '0;
            hc_reg <= hc; mc_reg <= mc; fc_reg <= fc; fa_reg <= fa;
            res_reg.hit_total <= hc;
            res_reg.miss_total <= mc;
            res_reg.fault_total <= fc;
            res_reg.fault_addr <= fa;
        end
    end

    `PW_ASSERT_NEXT(a_pop_work, clk, rst_n, pop, st_reg == BACK_WORK)
    `PW_ASSERT_IMP(a_second_last, clk, rst_n, st_reg == BACK_SECOND,
        done_reg && res_reg.kind == KIND_WRITE && !res_reg.last)
    `PW_ASSERT_IMP(a_hit_idx, clk, rst_n, hit_any, match_reg[hit_idx])
endmodule

[rtl/core/two_level_page_walk_with_tlb.sv]
// Top level of the two-level page walk with TLB.
// A command is taken when start is high and busy low; a two-deep queue
// buffers commands ahead of the back end. Each command occupies the back end
// for a queue pop, then the TLB compare result and answer; a completed walk
// adds a further state and emits its write request and translation on consecutive
// cycles. Results appear for one cycle under done and cannot be stalled.
// Walk reads leave as results and their data returns as response commands.
module two_level_page_walk_with_tlb
    import tlpw_pkg::*;
#(
    parameter int TLB_ENTRIES = TlbEntriesDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    in_word,
    output logic        done,
    output out_word_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic paging_reg;
    logic [19:0] dir_base_reg;
    logic cfg_write, pop, q_valid;
    queue_word_t q_word;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_reg <= 1'b0;
            dir_base_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_PAGING) paging_reg <= cfg_data[0];
            if (cfg_index == CFG_DIR_BASE) dir_base_reg <= cfg_data[19:0];
        end
    end

    tlpw_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word),
        .paging(paging_reg), .pop(pop), .busy(busy), .q_valid(q_valid),
        .q_word(q_word)
    );

    tlpw_back #(.TLB_ENTRIES(TLB_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word), .pop(pop),
        .dir_write(cfg_write && cfg_index == CFG_DIR_BASE), .dir_base(dir_base_reg),
        .done(done), .result(result)
    );
endmodule
